// File: src/hse_pkg.sv
// Shared types and constants of the heap sort engine.
// Used by hse_cell and heap_sort_engine; depends on nothing else.
package hse_pkg;

  localparam int unsigned MaxItems = 64;
  localparam int unsigned FillW    = $clog2(MaxItems + 1);

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               batch_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               final_flag;
  } out_item_t;

  // One value held in, or travelling along, the row of cells.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
  } slot_t;

endpackage

// File: src/hse_cell.sv
// One cell of the sorting row: keeps the smaller value, hands the larger on.
// Depends on hse_pkg for the slot type.
module hse_cell
  import hse_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  slot_t pass_i,
  input  slot_t right_i,
  output slot_t pass_o,
  output slot_t hold_o
);

  slot_t hold_q, hold_d;
  slot_t pass_q, pass_d;

  always_comb begin
    hold_d       = hold_q;
    pass_d       = '0;
    pass_d.value = pass_i.value;
    if (shift_i) begin
      hold_d = right_i;
    end else if (pass_i.valid) begin
      if (!hold_q.valid) begin
        hold_d = pass_i;
      end else if (pass_i.value < hold_q.value) begin
        // The newcomer is smaller: it stays and the old value moves on.
        hold_d = pass_i;
        pass_d = hold_q;
      end else begin
        pass_d = pass_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
      pass_q <= '0;
    end else begin
      hold_q <= hold_d;
      pass_q <= pass_d;
    end
  end

  assign pass_o = pass_q;
  assign hold_o = hold_q;

endmodule

// File: src/heap_sort_engine.sv
// Top level of the heap sort engine: a row of sorting cells and its sequencer.
// Depends on hse_pkg and hse_cell.
//
//  channel   | direction | transfer when               | payload
//  ----------+-----------+-----------------------------+----------------------------
//  input     | in        | start high and busy low     | in_i  (sample_value, end)
//  result    | out       | out_valid_o high            | out_o (sorted_value, final)
//
// Values are taken one per cycle while the batch loads; each moves one cell per
// cycle along the row until it settles in ascending place. After the closing
// transfer, busy stays high while values still travel and then while the row
// shifts towards cell zero, handing out the results without gaps. Reset empties
// the row at once. Results cannot be held off, so the emit phase never stalls.
module heap_sort_engine
  import hse_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  output out_item_t out_o
);

  typedef enum logic [1:0] {
    StLoad,
    StDrain,
    StEmit
  } state_e;

  state_e             state_q;
  logic [FillW-1:0]   fill_q;
  logic               accept;
  logic               close_batch;
  logic               in_flight;
  slot_t              inject;
  slot_t              pass_w  [MaxItems+1];
  slot_t              hold_w  [MaxItems+1];
  logic [MaxItems-1:0] pass_valid;
  logic               shift;

  assign busy        = (state_q != StLoad);
  assign accept      = start && !busy;
  assign close_batch = in_i.batch_end || (fill_q == FillW'(MaxItems - 1));
  assign shift       = (state_q == StEmit);

  always_comb begin
    inject.valid = accept;
    inject.value = in_i.sample_value;
  end

  assign pass_w[0]        = inject;
  assign hold_w[MaxItems] = '0;

  for (genvar i = 0; i < MaxItems; i++) begin : g_cell
    hse_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .pass_i  (pass_w[i]),
      .right_i (hold_w[i+1]),
      .pass_o  (pass_w[i+1]),
      .hold_o  (hold_w[i])
    );
    assign pass_valid[i] = pass_w[i+1].valid;
  end

  assign in_flight = |pass_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      fill_q  <= '0;
    end else begin
      case (state_q)
        StLoad: begin
          if (accept) begin
            if (close_batch) begin
              state_q <= StDrain;
              fill_q  <= '0;
            end else begin
              fill_q <= fill_q + FillW'(1);
            end
          end
        end
        StDrain: begin
          if (!in_flight) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (!hold_w[1].valid) begin
            state_q <= StLoad;
          end
        end
        default: begin
          state_q <= StLoad;
        end
      endcase
    end
  end

  assign out_valid_o        = (state_q == StEmit);
  assign out_o.sorted_value = hold_w[0].value;
  assign out_o.final_flag   = !hold_w[1].valid;

  // A result always comes from an occupied head cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hold_w[0].valid)
    else $error("result issued from an empty head cell");

  // Results of one run follow each other without gaps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.final_flag |=> out_valid_o)
    else $error("gap inside a sorted run");

  // The run ends by returning to loading.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.final_flag |=> !busy)
    else $error("engine still busy after the final result");

  // Successive results of one run never decrease.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && $past(out_valid_o) && !$past(out_o.final_flag)
      |-> out_o.sorted_value >= $past(out_o.sorted_value))
    else $error("results out of ascending order");

endmodule

// File: sim/tb_top.sv
// Self-checking bench for heap_sort_engine: loads batches of signed values and checks
// the ascending run that each batch produces. Needs hse_pkg and the engine RTL only.
module tb_top
  import hse_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [31:0] IntMin   = 32'sh8000_0000;
  localparam logic signed [31:0] IntMax   = 32'sh7fff_ffff;
  localparam int unsigned        RandGoal = 180;
  localparam int unsigned        StallMax = 4000;
  localparam int unsigned        DrainPad = 250;
  localparam int unsigned        DirCount = 21;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_i = '0;
  logic      out_valid_o;
  out_item_t out_o;

  out_item_t          sorted_expect[$];
  logic signed [31:0] open_batch[$];
  int unsigned        fail_count = 0;
  int unsigned        stall_cycles = 0;

  // Single-value batches have an obvious answer, so those rows carry it typed in.
  dir_row_t dir_rows [DirCount] = '{
    '{'{IntMin, 1'b1}, 1'b1, '{IntMin, 1'b1}},
    '{'{IntMax, 1'b1}, 1'b1, '{IntMax, 1'b1}},
    '{'{32'sd0, 1'b1}, 1'b1, '{32'sd0, 1'b1}},
    '{'{-32'sd1, 1'b1}, 1'b1, '{-32'sd1, 1'b1}},
    '{'{32'sd7, 1'b0}, 1'b0, '0},
    '{'{-32'sd7, 1'b1}, 1'b0, '0},
    '{'{IntMax, 1'b0}, 1'b0, '0},
    '{'{IntMin, 1'b0}, 1'b0, '0},
    '{'{32'sd0, 1'b0}, 1'b0, '0},
    '{'{-32'sd1, 1'b1}, 1'b0, '0},
    '{'{32'sd5, 1'b0}, 1'b0, '0},
    '{'{32'sd5, 1'b0}, 1'b0, '0},
    '{'{-32'sd5, 1'b0}, 1'b0, '0},
    '{'{32'sd5, 1'b1}, 1'b0, '0},
    '{'{32'sd3, 1'b0}, 1'b0, '0},
    '{'{32'sd2, 1'b0}, 1'b0, '0},
    '{'{32'sd1, 1'b0}, 1'b0, '0},
    '{'{32'sd0, 1'b1}, 1'b0, '0},
    '{'{32'sd1, 1'b0}, 1'b0, '0},
    '{'{32'sd2, 1'b0}, 1'b0, '0},
    '{'{32'sd3, 1'b1}, 1'b0, '0}
  };

  heap_sort_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Adds one value to the open batch; when the batch closes, queues it in ascending order.
  function automatic void take_sample(input in_item_t it);
    logic signed [31:0] ordered [MaxItems];
    logic signed [31:0] hold;
    int                 n;
    int                 j;
    out_item_t          res;
    open_batch.push_back(it.sample_value);
    if (!it.batch_end && open_batch.size() < MaxItems) return;
    n = open_batch.size();
    for (int i = 0; i < n; i++) begin
      hold = open_batch[i];
      j = i;
      while (j > 0 && ordered[j-1] > hold) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = hold;
    end
    for (int i = 0; i < n; i++) begin
      res.sorted_value = ordered[i];
      res.final_flag   = (i == n - 1);
      sorted_expect.push_back(res);
    end
    open_batch.delete();
  endfunction

  function automatic logic signed [31:0] random_sample();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return IntMin;
      1: return IntMax;
      2, 3: return $signed(32'($urandom_range(0, 8))) - 32'sd4;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 0;
    if (sel < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drives one sample and returns at the edge where the transfer takes place.
  task automatic send_sample(input in_item_t it, input int unsigned gap, input bit typed,
                             input out_item_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= it;
    do @(posedge clk_i); while (busy);
    if (typed) sorted_expect.push_back(want);
    else take_sample(it);
  endtask

  task automatic wait_drained();
    while (sorted_expect.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (sorted_expect.size() == 0) begin
        $error("result with nothing expected: sorted_value %0d", out_o.sorted_value);
        fail_count++;
      end else begin
        if (out_o.sorted_value !== sorted_expect[0].sorted_value) begin
          $error("sorted_value: expected %0d, got %0d",
                 sorted_expect[0].sorted_value, out_o.sorted_value);
          fail_count++;
        end
        if (out_o.final_flag !== sorted_expect[0].final_flag) begin
          $error("final_flag: expected %0d, got %0d",
                 sorted_expect[0].final_flag, out_o.final_flag);
          fail_count++;
        end
        void'(sorted_expect.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || out_valid_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallMax) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    in_item_t    it;
    int unsigned rand_items;
    int unsigned batch_len;
    int unsigned sel;
    bit          first_batch;
    bit          burst;
    rand_items  = 0;
    first_batch = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      send_sample(dir_rows[r].item, (r % 4 == 3) ? 2 : 0, dir_rows[r].typed,
                  dir_rows[r].want);
    end
    start <= 1'b0;
    wait_drained();

    // Random batches: mostly short ones, with a full store now and then, which
    // closes itself even when the last transfer does not flag the batch end.
    while (rand_items < RandGoal) begin
      sel = $urandom_range(0, 99);
      if (first_batch) batch_len = MaxItems;
      else if (sel < 60) batch_len = $urandom_range(1, 8);
      else if (sel < 82) batch_len = $urandom_range(9, 24);
      else if (sel < 90) batch_len = MaxItems;
      else batch_len = $urandom_range(40, MaxItems - 1);
      burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        start <= 1'b0;
        wait_drained();
      end
      for (int k = 0; k < batch_len; k++) begin
        it.sample_value = random_sample();
        it.batch_end    = (k == batch_len - 1) &&
                          !(batch_len == MaxItems && (first_batch || $urandom_range(0, 1) == 0));
        send_sample(it, burst ? 0 : idle_gap(), 1'b0, '0);
      end
      rand_items += batch_len;
      first_batch = 1'b0;
    end
    start <= 1'b0;

    wait_drained();
    repeat (DrainPad) @(posedge clk_i);
    if (sorted_expect.size() != 0) begin
      $error("%0d expected results never arrived", sorted_expect.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
src/hse_pkg.sv
src/hse_cell.sv
src/heap_sort_engine.sv
sim/tb_top.sv
